@@ rtl/swam_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor watchdog abort monitor package
// Event codes, register indexes, configuration and cause types, and the
// saturating increment that every silence counter shares.
// ----------------------------------------------------------------------------
package swam_pkg;

  localparam int unsigned CntW   = 8;
  localparam int unsigned DepthW = 16;
  localparam int unsigned SurfW  = 15;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned IdxW   = 3;

  localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};

  // Event kinds carried by cmd.
  localparam logic [CmdW-1:0] CMD_TICK  = 3'd0;
  localparam logic [CmdW-1:0] CMD_DEPTH = 3'd1;
  localparam logic [CmdW-1:0] CMD_GPS   = 3'd2;
  localparam logic [CmdW-1:0] CMD_SONAR = 3'd3;
  localparam logic [CmdW-1:0] CMD_MODE  = 3'd4;

  // Configuration register indexes.
  localparam logic [IdxW-1:0] REG_DEPTH_LIMIT  = 3'd0;
  localparam logic [IdxW-1:0] REG_SONAR_TO     = 3'd1;
  localparam logic [IdxW-1:0] REG_DEPTH_TO     = 3'd2;
  localparam logic [IdxW-1:0] REG_GPS_TO       = 3'd3;
  localparam logic [IdxW-1:0] REG_LOCK_LOSS    = 3'd4;
  localparam logic [IdxW-1:0] REG_SURFACE      = 3'd5;

  typedef struct packed {
    logic signed [DepthW-1:0] depth_limit_cm;
    logic [CntW-1:0]          sonar_timeout;
    logic [CntW-1:0]          depth_quiet_max;
    logic [CntW-1:0]          gps_quiet_max;
    logic [CntW-1:0]          lock_loss_pings;
    logic [SurfW-1:0]         surface_depth_cm;
  } cfg_t;

  typedef struct packed {
    logic abort;
    logic timeout_cause;
    logic lock_cause;
    logic depth_cause;
  } cause_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    return (c == CNT_MAX) ? c : c + {{(CntW-1){1'b0}}, 1'b1};
  endfunction

endpackage
`default_nettype wire

@@ rtl/swam_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor watchdog abort monitor core
// Holds the watchdog state, judges the abort causes on it and applies one
// registered event word per cycle while step is high.
// ----------------------------------------------------------------------------
module swam_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [swam_pkg::CmdW-1:0]     cmd,
  input  wire logic signed [swam_pkg::DepthW-1:0] depth_sample_cm,
  input  wire logic [7:0]                    track_status,
  input  wire logic                          altitude_mode,
  input  wire swam_pkg::cfg_t                cfg,
  output swam_pkg::cause_t                   causes
);
  import swam_pkg::*;

  logic [CntW-1:0]          sonar_silence;
  logic [CntW-1:0]          depth_silence;
  logic [CntW-1:0]          gps_silence;
  logic                     bottom_locked;
  logic [CntW-1:0]          bad_ping_run;
  logic signed [DepthW-1:0] last_depth_cm;
  logic                     in_altitude_mode;

  logic t_cause;
  logic near_surface;

  // Causes are judged on the state before the tick takes effect.
  always_comb begin
    t_cause = (sonar_silence > cfg.sonar_timeout) ||
              (depth_silence > cfg.depth_quiet_max) ||
              (gps_silence > cfg.gps_quiet_max);
    causes.timeout_cause = t_cause;
    causes.lock_cause    = in_altitude_mode && !bottom_locked;
    causes.depth_cause   = last_depth_cm > cfg.depth_limit_cm;
    causes.abort         = t_cause || causes.lock_cause || causes.depth_cause;
    near_surface = last_depth_cm < $signed({1'b0, cfg.surface_depth_cm});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sonar_silence    <= '0;
      depth_silence    <= '0;
      gps_silence      <= '0;
      bottom_locked    <= 1'b0;
      bad_ping_run     <= '0;
      last_depth_cm    <= '0;
      in_altitude_mode <= 1'b0;
    end else if (step) begin
      case (cmd)
        CMD_TICK: begin
          sonar_silence <= sat_inc(sonar_silence);
          depth_silence <= sat_inc(depth_silence);
          gps_silence   <= near_surface ? sat_inc(gps_silence) : '0;
        end
        CMD_DEPTH: begin
          depth_silence <= '0;
          last_depth_cm <= depth_sample_cm;
        end
        CMD_GPS: begin
          gps_silence <= '0;
        end
        CMD_SONAR: begin
          sonar_silence <= '0;
          if (track_status == 8'd0) begin
            bottom_locked <= 1'b1;
            bad_ping_run  <= '0;
          end else begin
            bottom_locked <= bad_ping_run <= cfg.lock_loss_pings;
            bad_ping_run  <= sat_inc(bad_ping_run);
          end
        end
        CMD_MODE: begin
          in_altitude_mode <= altitude_mode;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A saturated sonar counter stays saturated across a tick.
  a_sonar_sat: assert property (@(posedge clk) disable iff (rst)
    step && cmd == CMD_TICK && sonar_silence == CNT_MAX |=> sonar_silence == CNT_MAX)
    else $error("sonar silence counter wrapped");

  // A good ping always restores bottom lock and empties the bad-ping run.
  a_good_ping: assert property (@(posedge clk) disable iff (rst)
    step && cmd == CMD_SONAR && track_status == 8'd0 |=> bottom_locked && bad_ping_run == '0)
    else $error("good ping did not restore bottom lock");

  // Away from the surface a tick always clears the GPS counter.
  a_gps_clear: assert property (@(posedge clk) disable iff (rst)
    step && cmd == CMD_TICK && !near_surface |=> gps_silence == '0)
    else $error("GPS counter advanced below the surface band");
`endif

endmodule
`default_nettype wire

@@ rtl/swam_result_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor watchdog abort monitor result register
// Holds one finished verdict word until the consumer takes it.
// ----------------------------------------------------------------------------
module swam_result_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire swam_pkg::cause_t load_causes,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output swam_pkg::cause_t      held
);
  import swam_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_causes;
    end
  end

`ifndef NO_ASSERTIONS
  // The owner only loads when the register is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("result register overwritten while a verdict waits");
`endif

endmodule
`default_nettype wire

@@ rtl/sensor_watchdog_abort_monitor_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor watchdog abort monitor
// Watches depth, GPS, sonar and mode events and gives an abort verdict on
// every heartbeat tick.
// ----------------------------------------------------------------------------
// The block takes one event word per clock cycle, back to back, while
// in_ready is high. A word is first captured in an input register; the core
// applies it to the watchdog state as it leaves that register, and a tick
// also writes its verdict into the result register, which drives the output.
// Events other than ticks (depth, GPS fix, sonar ping, mode update) give no
// output word and never wait on the consumer; unknown event codes are
// dropped without touching the state. A tick waits in the input register
// only while a previous verdict is still held and the consumer is not
// ready, so with out_ready high the sustained rate is one word per cycle,
// set by the single input register and single result register.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data at any clock edge with cfg_we high; writes to indexes beyond
// the six registers are ignored. After reset no clearing pass is needed.
// ----------------------------------------------------------------------------
module sensor_watchdog_abort_monitor_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Event input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic signed [15:0] depth_sample_cm,
  input  wire logic [7:0]  track_status,
  input  wire logic        altitude_mode,
  // Verdict output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             abort,
  output logic             timeout_cause,
  output logic             lock_cause,
  output logic             depth_cause
);
  import swam_pkg::*;

  cfg_t cfg;

  // Input register: one event word waiting to be applied.
  logic                     stage_valid;
  logic [CmdW-1:0]          stage_cmd;
  logic signed [DepthW-1:0] stage_depth;
  logic [7:0]               stage_track;
  logic                     stage_mode;

  logic   advance;
  logic   stage_is_tick;
  logic   can_load;
  cause_t causes;
  cause_t held;

  // Configuration registers. Each register keeps only its own width of the
  // write data; a write to an unused index changes nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_limit_cm   <= 16'sd32767;
      cfg.sonar_timeout    <= 8'd10;
      cfg.depth_quiet_max  <= 8'd10;
      cfg.gps_quiet_max    <= 8'd10;
      cfg.lock_loss_pings  <= 8'd10;
      cfg.surface_depth_cm <= 15'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH_LIMIT: cfg.depth_limit_cm <= $signed(cfg_data);
        REG_SONAR_TO:  cfg.sonar_timeout    <= cfg_data[CntW-1:0];
        REG_DEPTH_TO:  cfg.depth_quiet_max  <= cfg_data[CntW-1:0];
        REG_GPS_TO:    cfg.gps_quiet_max    <= cfg_data[CntW-1:0];
        REG_LOCK_LOSS: cfg.lock_loss_pings  <= cfg_data[CntW-1:0];
        REG_SURFACE:   cfg.surface_depth_cm <= cfg_data[SurfW-1:0];
        default: begin
        end
      endcase
    end
  end

  // A staged word moves on when it needs no result slot, or when the result
  // register is free or being emptied in this cycle.
  assign stage_is_tick = stage_cmd == CMD_TICK;
  assign advance       = stage_valid && (!stage_is_tick || can_load);
  assign in_ready      = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_cmd   <= cmd;
      stage_depth <= depth_sample_cm;
      stage_track <= track_status;
      stage_mode  <= altitude_mode;
    end
  end

  swam_core u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .cmd             (stage_cmd),
    .depth_sample_cm (stage_depth),
    .track_status    (stage_track),
    .altitude_mode   (stage_mode),
    .cfg             (cfg),
    .causes          (causes)
  );

  swam_result_reg u_result (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && stage_is_tick),
    .load_causes (causes),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .held        (held)
  );

  assign abort         = held.abort;
  assign timeout_cause = held.timeout_cause;
  assign lock_cause    = held.lock_cause;
  assign depth_cause   = held.depth_cause;

`ifndef NO_ASSERTIONS
  // A tick that leaves the input register always lands as a verdict.
  a_tick_verdict: assert property (@(posedge clk) disable iff (rst)
    advance && stage_is_tick |=> out_valid)
    else $error("tick applied without a verdict");

  // Non-tick words never stall in the input register.
  a_event_flows: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage_is_tick |-> advance && in_ready)
    else $error("sensor event stalled behind the result register");

  // An abort verdict always carries at least one cause.
  a_abort_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && abort |-> timeout_cause || lock_cause || depth_cause)
    else $error("abort without a cause");
`endif

endmodule
`default_nettype wire
